// File: rtl/loco_i_context_predictor_macros.svh
// ----------------------------------------------------------------------------
// LOCO-I context predictor assertion macros
// Shared concurrent assertion forms for the predictor RTL.
// ----------------------------------------------------------------------------
`ifndef LOCO_I_CONTEXT_PREDICTOR_MACROS_SVH
`define LOCO_I_CONTEXT_PREDICTOR_MACROS_SVH

// Check a consequence in the same cycle.
`define LCP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define LCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lcp_pkg.sv
// ----------------------------------------------------------------------------
// LOCO-I context predictor package
// Transaction types, context entry type and shared constants.
// ----------------------------------------------------------------------------
package lcp_pkg;

    localparam int PIX_W        = 8;
    localparam int KIDX_W       = 7;
    localparam int ERR_W        = 9;
    localparam int BIAS_W       = 11;
    localparam int COUNT_W      = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE         = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd256;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd256;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [KIDX_W-1:0] KIDX_MIN = 7'd1;
    localparam logic [KIDX_W-1:0] KIDX_MAX = 7'd124;

    localparam logic [ERR_W-1:0] QUANT_T1 = 9'd2;
    localparam logic [ERR_W-1:0] QUANT_T2 = 9'd6;
    localparam logic [ERR_W-1:0] QUANT_T3 = 9'd20;

    localparam logic [COUNT_W-1:0]   HALVE_LIMIT = 10'd640;
    localparam logic signed [PIX_W:0] BC_MIN     = -9'sd128;
    localparam logic signed [PIX_W:0] BC_MAX     = 9'sd127;

    typedef struct packed {
        logic [PIX_W-1:0]        pixel_in;
        logic signed [PIX_W-1:0] residual_in;
    } lcp_in_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] folded_residual;
        logic [PIX_W-1:0]        pixel_out;
        logic [KIDX_W-1:0]       context_index;
        logic                    frame_end;
    } lcp_out_t;

    typedef struct packed {
        logic signed [BIAS_W-1:0] bias_sum;
        logic [COUNT_W-1:0]       hit_count;
        logic signed [PIX_W-1:0]  bias_correction;
    } ctx_entry_t;

    localparam ctx_entry_t CTX_RESET = '{bias_sum: '0, hit_count: 10'd1, bias_correction: '0};

    typedef struct packed {
        logic                    rd_en;
        logic [KIDX_W-1:0]       k;
        logic                    upd_en;
        logic signed [ERR_W-1:0] err;
        logic                    clear;
    } lcp_ctx_req_t;

endpackage

// File: rtl/loco_i_context_predictor.sv
// ----------------------------------------------------------------------------
// LOCO-I context predictor
// Raster-order lossless image modeler: MED prediction with per-context bias
// correction; encode gives folded residuals, decode rebuilds pixels, both give
// the context index. A new transaction is taken only once the previous one has
// left the prediction step: in the accept cycle the neighbours form the context
// index that addresses the context memory, and in the prediction step the
// registered context entry yields the corrected prediction, the result and the
// row-store write; the context update is registered and written back from that
// register, and is forwarded to a following read of the same context. The
// decode loop from one reconstructed pixel through the context memory read to
// the next sets this limit. A result is registered in the stage registers and
// then in the output register; a stalled output holds the block after one
// further transaction has been accepted. Contexts reset through valid bits, so
// there is no clearing pass after reset or at the end of a frame.
// ----------------------------------------------------------------------------
`include "loco_i_context_predictor_macros.svh"

module loco_i_context_predictor
    import lcp_pkg::*;
#(
    parameter int MAX_LINE      = 4096,
    parameter int CONTEXT_SLOTS = 128
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  lcp_in_t                item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output lcp_out_t               result
);

    localparam int XW   = $clog2(MAX_LINE);
    localparam int WLOG = $clog2(MAX_LINE + 1);
    localparam int WW   = ((WLOG > WIDTH_REG_W) ? WLOG : WIDTH_REG_W) + 1;
    localparam int HW   = HEIGHT_REG_W + 1;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    mode_reg;

    logic [XW-1:0]           col_reg;
    logic [XW-1:0]           col_next;
    logic [HEIGHT_REG_W-1:0] row_reg;
    logic [HEIGHT_REG_W-1:0] row_next;
    logic [PIX_W-1:0]        left_reg;
    logic [PIX_W-1:0]        upleft_reg;

    logic                    p1_reg;
    logic                    accept;
    logic                    p1_done;
    lcp_in_t                 item_reg;
    logic [KIDX_W-1:0]       k_reg;
    logic                    neg_reg;
    logic [PIX_W-1:0]        pmed_reg;
    logic [PIX_W-1:0]        up_reg;

    logic                    result_valid_reg;
    lcp_out_t                result_reg;

    logic [WW-1:0]           w_sel;
    logic [WW-1:0]           w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    has_left;
    logic                    has_up;
    logic                    last_col;
    logic                    last_row;
    logic                    frame_last;

    logic [PIX_W-1:0]        up_raw;
    logic [PIX_W-1:0]        upright_raw;
    logic [PIX_W-1:0]        nb_a;
    logic [PIX_W-1:0]        nb_b;
    logic [PIX_W-1:0]        nb_c;
    logic [PIX_W-1:0]        nb_d;
    logic signed [ERR_W-1:0] g1;
    logic signed [ERR_W-1:0] g2;
    logic signed [ERR_W-1:0] g3;
    logic signed [3:0]       q1;
    logic signed [3:0]       q2;
    logic signed [3:0]       q3;
    logic signed [3:0]       n1;
    logic signed [3:0]       n2;
    logic signed [3:0]       n3;
    logic                    neg;
    logic signed [ERR_W-1:0] ksum;
    logic [KIDX_W-1:0]       k_comb;
    logic [PIX_W-1:0]        mx;
    logic [PIX_W-1:0]        mn;
    logic [PIX_W:0]          ab_sum;
    logic [PIX_W-1:0]        pmed;

    logic signed [PIX_W-1:0] ctx_c;
    logic signed [PIX_W+1:0] pc_raw;
    logic [PIX_W-1:0]        pc_val;
    logic [PIX_W-1:0]        cur;
    logic signed [PIX_W-1:0] fold;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] err_norm;

    lcp_ctx_req_t            ctx_req;

    function automatic logic signed [3:0] quantize(input logic signed [ERR_W-1:0] g);
        logic [ERR_W-1:0] m;
        logic [3:0]       q;
        m = g[ERR_W-1] ? ERR_W'(-g) : g;
        if (m == '0)
        begin
            q = 4'd0;
        end
        else if (m <= QUANT_T1)
        begin
            q = 4'd1;
        end
        else if (m <= QUANT_T2)
        begin
            q = 4'd2;
        end
        else if (m <= QUANT_T3)
        begin
            q = 4'd3;
        end
        else
        begin
            q = 4'd4;
        end
        return g[ERR_W-1] ? -$signed(q) : $signed(q);
    endfunction

    assign cfg_ready    = 1'b1;
    assign item_ready   = !p1_reg;
    assign accept       = item_valid && item_ready;
    assign p1_done      = p1_reg && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Position and frame geometry
    assign w_sel      = (width_reg == '0) ? WW'(1) : WW'(width_reg);
    assign w_eff      = (w_sel > WW'(MAX_LINE)) ? WW'(MAX_LINE) : w_sel;
    assign h_eff      = (height_reg == '0) ? HEIGHT_REG_W'(1) : height_reg;
    assign has_left   = (col_reg != '0);
    assign has_up     = (row_reg != '0);
    assign last_col   = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign last_row   = (HW'(row_reg) + HW'(1)) >= HW'(h_eff);
    assign frame_last = last_col && last_row;

    assign col_next = last_col ? '0 : XW'(col_reg + 1'b1);
    assign row_next = last_col ? (last_row ? '0 : HEIGHT_REG_W'(row_reg + 1'b1)) : row_reg;

    // Context formation and MED prediction
    assign nb_a = has_left ? left_reg : '0;
    assign nb_c = (has_left && has_up) ? upleft_reg : '0;
    assign nb_b = has_up ? up_raw : '0;
    assign nb_d = (has_up && !last_col) ? upright_raw : '0;

    assign g1 = ERR_W'({1'b0, nb_d}) - ERR_W'({1'b0, nb_b});
    assign g2 = ERR_W'({1'b0, nb_b}) - ERR_W'({1'b0, nb_c});
    assign g3 = ERR_W'({1'b0, nb_c}) - ERR_W'({1'b0, nb_a});
    assign q1 = quantize(g1);
    assign q2 = quantize(g2);
    assign q3 = quantize(g3);

    assign neg = (q1 < 0) || ((q1 == 0) && ((q2 < 0) || ((q2 == 0) && (q3 < 0))));
    assign n1  = neg ? -q1 : q1;
    assign n2  = neg ? -q2 : q2;
    assign n3  = neg ? -q3 : q3;

    assign ksum   = ERR_W'(25 * n1 + 5 * n2 + n3);
    assign k_comb = (ksum == '0) ? KIDX_MIN : ksum[KIDX_W-1:0];

    assign mx     = (nb_a > nb_b) ? nb_a : nb_b;
    assign mn     = (nb_a < nb_b) ? nb_a : nb_b;
    assign ab_sum = {1'b0, nb_a} + {1'b0, nb_b};

    always_comb
    begin
        if (nb_c >= mx)
        begin
            pmed = mn;
        end
        else if (nb_c <= mn)
        begin
            pmed = mx;
        end
        else
        begin
            pmed = PIX_W'(ab_sum - {1'b0, nb_c});
        end
    end

    // Bias-corrected prediction and residual
    always_comb
    begin
        if (neg_reg)
        begin
            pc_raw = $signed({2'b00, pmed_reg}) - $signed({{2{ctx_c[PIX_W-1]}}, ctx_c});
        end
        else
        begin
            pc_raw = $signed({2'b00, pmed_reg}) + $signed({{2{ctx_c[PIX_W-1]}}, ctx_c});
        end
        if (pc_raw[PIX_W+1])
        begin
            pc_val = '0;
        end
        else if (pc_raw[PIX_W])
        begin
            pc_val = '1;
        end
        else
        begin
            pc_val = pc_raw[PIX_W-1:0];
        end
        if (mode_reg == MODE_DECODE)
        begin
            fold = item_reg.residual_in;
            cur  = PIX_W'(pc_val + $unsigned(item_reg.residual_in));
        end
        else
        begin
            cur  = item_reg.pixel_in;
            fold = $signed(PIX_W'(item_reg.pixel_in - pc_val));
        end
        err      = ERR_W'({1'b0, cur}) - ERR_W'({1'b0, pc_val});
        err_norm = neg_reg ? ERR_W'(-err) : err;
    end

    assign ctx_req.rd_en  = accept;
    assign ctx_req.k      = k_comb;
    assign ctx_req.upd_en = p1_done;
    assign ctx_req.err    = err_norm;
    assign ctx_req.clear  = p1_done && frame_last;

    lcp_row_buffer #(
        .MAX_LINE (MAX_LINE)
    ) u_row_buffer (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_en         (p1_done),
        .rd_addr       (col_next),
        .wr_en         (p1_done),
        .wr_addr       (col_reg),
        .wr_data       (cur),
        .up_pixel      (up_raw),
        .upright_pixel (upright_raw)
    );

    lcp_context_store #(
        .CONTEXT_SLOTS (CONTEXT_SLOTS)
    ) u_context_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ctx_req),
        .ctx_c (ctx_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            mode_reg   <= MODE_ENCODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                CFG_MODE:         mode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            col_reg          <= '0;
            row_reg          <= '0;
            left_reg         <= '0;
            upleft_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                p1_reg <= 1'b1;
            end
            else if (p1_done)
            begin
                p1_reg <= 1'b0;
            end
            if (p1_done)
            begin
                result_valid_reg <= 1'b1;
                col_reg          <= col_next;
                row_reg          <= row_next;
                left_reg         <= cur;
                upleft_reg       <= up_reg;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            k_reg    <= k_comb;
            neg_reg  <= neg;
            pmed_reg <= pmed;
            up_reg   <= nb_b;
        end
        if (p1_done)
        begin
            result_reg.folded_residual <= fold;
            result_reg.pixel_out       <= cur;
            result_reg.context_index   <= k_reg;
            result_reg.frame_end       <= frame_last;
        end
    end

    `LCP_ASSERT_NEXT(a_accept_to_predict, clk, rst_n, accept, p1_reg, "accepted transaction lost before prediction")
    `LCP_ASSERT_NEXT(a_done_loads_result, clk, rst_n, p1_done, result_valid_reg, "finished transaction gave no result")
    `LCP_ASSERT_NEXT(a_frame_wrap, clk, rst_n, p1_done && frame_last, (col_reg == '0) && (row_reg == '0), "position did not return to origin at frame end")
    `LCP_ASSERT_SAME(a_index_range, clk, rst_n, result_valid_reg, (result_reg.context_index >= KIDX_MIN) && (result_reg.context_index <= KIDX_MAX), "context index out of range")

endmodule

// File: rtl/lcp_row_buffer.sv
// ----------------------------------------------------------------------------
// LCP row buffer
// Previous-row pixel memory with two registered read ports for the up and
// up-right neighbours and bypass of a write to the same entry.
// ----------------------------------------------------------------------------
module lcp_row_buffer
    import lcp_pkg::*;
#(
    parameter int MAX_LINE = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_LINE)-1:0]   rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_LINE)-1:0]   wr_addr,
    input  logic [PIX_W-1:0]              wr_data,
    output logic [PIX_W-1:0]              up_pixel,
    output logic [PIX_W-1:0]              upright_pixel
);

    localparam int XW = $clog2(MAX_LINE);
    localparam logic [XW-1:0] LAST_ADDR = XW'(MAX_LINE - 1);

    logic [PIX_W-1:0] mem [MAX_LINE];
    logic [XW-1:0]    addr_d;
    logic [PIX_W-1:0] rd_b_reg;
    logic [PIX_W-1:0] rd_d_reg;
    logic [PIX_W-1:0] byp_data_reg;
    logic             byp_b_reg;
    logic             byp_d_reg;

    assign addr_d = (rd_addr == LAST_ADDR) ? '0 : XW'(rd_addr + 1'b1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_b_reg     <= mem[rd_addr];
            rd_d_reg     <= mem[addr_d];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_b_reg <= 1'b0;
            byp_d_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_b_reg <= wr_en && (wr_addr == rd_addr);
            byp_d_reg <= wr_en && (wr_addr == addr_d);
        end
    end

    assign up_pixel      = byp_b_reg ? byp_data_reg : rd_b_reg;
    assign upright_pixel = byp_d_reg ? byp_data_reg : rd_d_reg;

endmodule

// File: rtl/lcp_context_store.sv
// ----------------------------------------------------------------------------
// LCP context store
// Context memory (bias sum, hit count, bias correction) with valid bits,
// registered read, a registered read-modify-write update and forwarding.
// ----------------------------------------------------------------------------
module lcp_context_store
    import lcp_pkg::*;
#(
    parameter int CONTEXT_SLOTS = 128
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lcp_ctx_req_t            req,
    output logic signed [PIX_W-1:0] ctx_c
);

    localparam int AW = $clog2(CONTEXT_SLOTS);
    localparam int BW = BIAS_W + 1;

    ctx_entry_t              mem [CONTEXT_SLOTS];
    logic [CONTEXT_SLOTS-1:0] vld_reg;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           rd_addr_reg;
    ctx_entry_t              rd_data_reg;
    logic                    vld_rd_reg;
    logic                    fwd_hit_reg;
    ctx_entry_t              fwd_entry_reg;
    ctx_entry_t              cur_entry;

    logic                    p2_valid_reg;
    logic [AW-1:0]           p2_addr_reg;
    logic signed [ERR_W-1:0] p2_err_reg;
    ctx_entry_t              p2_entry_reg;
    ctx_entry_t              upd_entry;

    logic signed [BW-1:0]    b_sum;
    logic signed [BW-1:0]    b_half;
    logic signed [BW-1:0]    b_adj;
    logic signed [BW-1:0]    n_ext;
    logic [COUNT_W-1:0]      n_inc;
    logic [COUNT_W-1:0]      n_new;
    logic signed [PIX_W:0]   c_ext;
    logic signed [PIX_W:0]   c_adj;
    logic signed [PIX_W:0]   c_sat;

    assign rd_addr = AW'(req.k);

    assign cur_entry = fwd_hit_reg ? fwd_entry_reg
                     : (vld_rd_reg ? rd_data_reg : CTX_RESET);
    assign ctx_c     = cur_entry.bias_correction;

    always_comb
    begin
        b_sum = {p2_entry_reg.bias_sum[BIAS_W-1], p2_entry_reg.bias_sum}
              + {{(BW - ERR_W){p2_err_reg[ERR_W-1]}}, p2_err_reg};
        n_inc = p2_entry_reg.hit_count + 1'b1;
        if (n_inc >= HALVE_LIMIT)
        begin
            n_new  = n_inc >> 1;
            b_half = b_sum >>> 1;
        end
        else
        begin
            n_new  = n_inc;
            b_half = b_sum;
        end
        n_ext = $signed({{(BW - COUNT_W){1'b0}}, n_new});
        c_ext = {p2_entry_reg.bias_correction[PIX_W-1], p2_entry_reg.bias_correction};
        if (b_half <= -n_ext)
        begin
            c_adj = c_ext - 9'sd1;
            b_adj = b_half + n_ext;
            if (b_adj <= -n_ext)
            begin
                b_adj = -n_ext + 12'sd1;
            end
        end
        else if (b_half > 12'sd0)
        begin
            c_adj = c_ext + 9'sd1;
            b_adj = b_half - n_ext;
            if (b_adj > 12'sd0)
            begin
                b_adj = '0;
            end
        end
        else
        begin
            c_adj = c_ext;
            b_adj = b_half;
        end
        if (c_adj < BC_MIN)
        begin
            c_sat = BC_MIN;
        end
        else if (c_adj > BC_MAX)
        begin
            c_sat = BC_MAX;
        end
        else
        begin
            c_sat = c_adj;
        end
        upd_entry.bias_sum        = b_adj[BIAS_W-1:0];
        upd_entry.hit_count       = n_new;
        upd_entry.bias_correction = c_sat[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg)
        begin
            mem[p2_addr_reg] <= upd_entry;
        end
        if (req.rd_en)
        begin
            rd_data_reg   <= mem[rd_addr];
            rd_addr_reg   <= rd_addr;
            fwd_entry_reg <= upd_entry;
        end
        if (req.upd_en)
        begin
            p2_addr_reg  <= rd_addr_reg;
            p2_err_reg   <= req.err;
            p2_entry_reg <= cur_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            vld_rd_reg   <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                vld_reg <= '0;
            end
            else if (p2_valid_reg)
            begin
                vld_reg[p2_addr_reg] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vld_rd_reg  <= vld_reg[rd_addr];
                fwd_hit_reg <= p2_valid_reg && (rd_addr == p2_addr_reg);
            end
            p2_valid_reg <= req.upd_en && !req.clear;
        end
    end

endmodule
